// File: hw/rtl/fsm_pkg.sv
// shared constants and types for the file name spelling matcher
package fsm_pkg;

  localparam int GUESS_MAX  = 14;
  localparam int CAND_MAX   = 16;
  localparam int MAX_LEN    = (GUESS_MAX > CAND_MAX) ? GUESS_MAX : CAND_MAX;
  localparam int GUESS_AW   = $clog2(GUESS_MAX);
  localparam int CAND_AW    = $clog2(CAND_MAX);
  localparam int GUESS_LW   = $clog2(GUESS_MAX + 1);
  localparam int CAND_LW    = $clog2(CAND_MAX + 1);
  localparam int POS_W      = $clog2(MAX_LEN + 3);
  localparam int IDX_W      = 16;
  localparam int PREFIX_MIN = 3;

  localparam logic [2:0] RATE_EXACT  = 3'd0;
  localparam logic [2:0] RATE_SWAP   = 3'd1;
  localparam logic [2:0] RATE_EDIT   = 3'd2;
  localparam logic [2:0] RATE_PREFIX = 3'd3;
  localparam logic [2:0] RATE_NONE   = 3'd4;

  localparam logic [1:0] FUNC_GUESS = 2'd0;
  localparam logic [1:0] FUNC_CAND  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

endpackage

// File: hw/rtl/filename_spelling_matcher.sv
// file name spelling matcher: guess and candidate buffers with a rating walk
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | func, ch, last
//  out     | output    | out_valid / out_ready | distance, became_best, best_distance,
//          |           |                       | best_index, search_done
//
// a guess, clear or non-final candidate item leaves the block idle, ready for the next item
// a final candidate item (if no exact match has stopped the search) starts the rating walk,
//   and no item is taken until its result is loaded into the output register; the walk
//   reads one position per cycle from the guess and candidate memories (one read port each)
// the result sits in an output register; a new rating waits there only if it is still full
// guess and clear items are taken while a result waits
// synchronous reset clears lengths, best entry, counters and flags; the byte memories are not
//   cleared, only bytes below the stored length are ever used
module filename_spelling_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  distance,
  output logic        became_best,
  output logic [2:0]  best_distance,
  output logic [15:0] best_index,
  output logic        search_done
);

  localparam int PW = fsm_pkg::POS_W;

  // byte memories
  logic [7:0] guess_mem [fsm_pkg::GUESS_MAX];
  logic [7:0] cand_mem  [fsm_pkg::CAND_MAX];

  // name state
  logic [fsm_pkg::GUESS_LW-1:0] guess_len;
  logic [fsm_pkg::CAND_LW-1:0]  cand_len;
  logic                         cand_overflow;
  logic                         guess_closed;
  logic [2:0]                   best_rating;
  logic [fsm_pkg::IDX_W-1:0]    best_entry;
  logic [fsm_pkg::IDX_W-1:0]    entry_count;
  logic                         exact_found;

  fsm_pkg::state_t state, state_next;

  // walk registers
  logic [PW-1:0] ra;      // read address issued this cycle
  logic [PW-1:0] kd;      // position of the data now on the read ports
  logic          dv;      // read data valid
  logic [7:0]    c_rd, g_rd;
  logic [7:0]    pc, pg;  // bytes of the previous position
  logic          found;   // first mismatch seen
  logic [PW-1:0] mis;     // first mismatch position
  logic          eq1, eq2, sc, sg, sw;

  // memory write controls
  logic g_we, c_we;

  logic [PW-1:0] m_w, n_w, len_max, ie;
  logic          k_lt_m, k_lt_n, k_both;
  logic [2:0]    rating;
  logic          took;
  logic          commit;

  assign m_w     = PW'(cand_len);
  assign n_w     = PW'(guess_len);
  assign len_max = (m_w > n_w) ? m_w : n_w;

  assign in_ready = (state == fsm_pkg::S_IDLE);

  assign g_we = in_valid && in_ready && (func == fsm_pkg::FUNC_GUESS) && !guess_closed
                && (guess_len < fsm_pkg::GUESS_LW'(fsm_pkg::GUESS_MAX));
  assign c_we = in_valid && in_ready && (func == fsm_pkg::FUNC_CAND) && !exact_found
                && (cand_len < fsm_pkg::CAND_LW'(fsm_pkg::CAND_MAX));

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (g_we) begin
      guess_mem[guess_len[fsm_pkg::GUESS_AW-1:0]] <= ch;
    end
    if (ra < PW'(fsm_pkg::GUESS_MAX)) begin
      g_rd <= guess_mem[ra[fsm_pkg::GUESS_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cand_mem[cand_len[fsm_pkg::CAND_AW-1:0]] <= ch;
    end
    if (ra < PW'(fsm_pkg::CAND_MAX)) begin
      c_rd <= cand_mem[ra[fsm_pkg::CAND_AW-1:0]];
    end
  end

  // position tests for the byte pair on the read ports
  assign k_lt_m = kd < m_w;
  assign k_lt_n = kd < n_w;
  assign k_both = k_lt_m && k_lt_n;

  // rating of the finished walk; a run with no mismatch stops at the longer length
  assign ie = found ? mis : len_max;

  always_comb begin
    rating = fsm_pkg::RATE_NONE;
    if (cand_overflow) begin
      // long candidate: only a guess prefix of the stored bytes counts
      if (n_w >= PW'(fsm_pkg::PREFIX_MIN) && n_w <= m_w && ie >= n_w) begin
        rating = fsm_pkg::RATE_PREFIX;
      end
    end else if (ie == m_w && ie == n_w) begin
      rating = fsm_pkg::RATE_EXACT;
    end else if (ie >= PW'(fsm_pkg::PREFIX_MIN) && ie == n_w) begin
      rating = fsm_pkg::RATE_PREFIX;
    end else if (ie < m_w && ie < n_w && (ie + 1'b1) < m_w && (ie + 1'b1) < n_w
                 && sw && m_w == n_w && eq2) begin
      rating = fsm_pkg::RATE_SWAP;
    end else if (ie < m_w && ie < n_w && m_w == n_w && eq1) begin
      rating = fsm_pkg::RATE_EDIT;
    end else if (ie < m_w && m_w == n_w + 1'b1 && sc) begin
      rating = fsm_pkg::RATE_EDIT;
    end else if (ie < n_w && n_w == m_w + 1'b1 && sg) begin
      rating = fsm_pkg::RATE_EDIT;
    end
  end

  assign took   = (rating != fsm_pkg::RATE_NONE) && (rating <= best_rating);
  assign commit = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fsm_pkg::S_IDLE: begin
        if (in_valid && func == fsm_pkg::FUNC_CAND && !exact_found && last) begin
          state_next = fsm_pkg::S_WALK;
        end
      end
      fsm_pkg::S_WALK: begin
        if (ra >= len_max && !dv) begin
          state_next = fsm_pkg::S_FIN;
        end
      end
      fsm_pkg::S_FIN: begin
        if (commit) begin
          state_next = fsm_pkg::S_IDLE;
        end
      end
      default: state_next = fsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and name state
  always_ff @(posedge clk) begin
    if (rst) begin
      guess_len     <= '0;
      cand_len      <= '0;
      cand_overflow <= 1'b0;
      guess_closed  <= 1'b0;
      best_rating   <= fsm_pkg::RATE_NONE;
      best_entry    <= '0;
      entry_count   <= '0;
      exact_found   <= 1'b0;
      out_valid     <= 1'b0;
      ra            <= '0;
      dv            <= 1'b0;
      found         <= 1'b0;
    end else begin
      // in the final state the result register is reloaded below
      if (out_valid && out_ready && state != fsm_pkg::S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        fsm_pkg::S_IDLE: begin
          ra    <= '0;
          dv    <= 1'b0;
          found <= 1'b0;
          mis   <= '0;
          eq1   <= 1'b1;
          eq2   <= 1'b1;
          sc    <= 1'b1;
          sg    <= 1'b1;
          sw    <= 1'b0;
          if (in_valid) begin
            case (func)
              fsm_pkg::FUNC_GUESS: begin
                if (!guess_closed) begin
                  if (g_we) begin
                    guess_len <= guess_len + 1'b1;
                  end
                  if (last) begin
                    guess_closed <= 1'b1;
                  end
                end
              end
              fsm_pkg::FUNC_CAND: begin
                if (!exact_found) begin
                  if (c_we) begin
                    cand_len <= cand_len + 1'b1;
                  end else begin
                    cand_overflow <= 1'b1;
                  end
                end
              end
              fsm_pkg::FUNC_CLEAR: begin
                guess_len     <= '0;
                cand_len      <= '0;
                cand_overflow <= 1'b0;
                guess_closed  <= 1'b0;
                best_rating   <= fsm_pkg::RATE_NONE;
                best_entry    <= '0;
                entry_count   <= '0;
                exact_found   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        fsm_pkg::S_WALK: begin
          // issue side
          if (ra < len_max) begin
            ra <= ra + 1'b1;
            kd <= ra;
            dv <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          // compare side
          if (dv) begin
            pc <= c_rd;
            pg <= g_rd;
            if (!found) begin
              if (!(k_both && c_rd == g_rd)) begin
                found <= 1'b1;
                mis   <= kd;
              end
            end else begin
              if (k_both) begin
                eq1 <= eq1 && (c_rd == g_rd);
              end
              if (k_both && kd != mis + 1'b1) begin
                eq2 <= eq2 && (c_rd == g_rd);
              end
              if (kd == mis + 1'b1) begin
                sw <= k_both && (pc == g_rd) && (pg == c_rd);
              end
              // candidate has one extra byte
              if (k_lt_m) begin
                sc <= sc && (c_rd == pg);
              end
              // guess has one extra byte
              if (k_lt_n) begin
                sg <= sg && (g_rd == pc);
              end
            end
          end
        end
        fsm_pkg::S_FIN: begin
          if (commit) begin
            if (took) begin
              best_rating <= rating;
              best_entry  <= entry_count;
              if (rating == fsm_pkg::RATE_EXACT) begin
                exact_found <= 1'b1;
              end
            end
            entry_count   <= entry_count + 1'b1;
            cand_len      <= '0;
            cand_overflow <= 1'b0;
            out_valid     <= 1'b1;
            distance      <= rating;
            became_best   <= took;
            best_distance <= took ? rating : best_rating;
            best_index    <= took ? entry_count : best_entry;
            search_done   <= exact_found || (took && rating == fsm_pkg::RATE_EXACT);
          end
        end
        default: ;
      endcase
    end
  end

  // a replaced best entry carries this item's own rating
  a_best_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && became_best |-> best_distance == distance)
    else $error("best rating differs from the rating that replaced it");

  // a stopped search always reports an exact best
  a_done_exact: assert property (@(posedge clk) disable iff (rst)
    out_valid && search_done |-> best_distance == fsm_pkg::RATE_EXACT)
    else $error("search stopped without an exact best");

  // the walk has drained its read pipeline before the rating is taken
  a_walk_drained: assert property (@(posedge clk) disable iff (rst)
    state == fsm_pkg::S_FIN |-> !dv && ra >= len_max)
    else $error("rating taken before the walk finished");

  // no new result is loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_index) && $stable(distance))
    else $error("waiting result overwritten");

endmodule

// File: dv/tb_filename_spelling_matcher.sv
// self-checking testbench for the file name spelling matcher
`timescale 1ns / 100ps

module tb_filename_spelling_matcher;

  // func 3 is unused by the block and must be ignored
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int unsigned ITEMS_TOTAL  = 1150;
  localparam int unsigned CALM_AT      = 1000;  // no idling from here on
  localparam int unsigned HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int unsigned LIMIT_CYCLES = 3000;  // watchdog: cycles without any handshake
  localparam int unsigned DRAIN_CYCLES = 4 * (fsm_pkg::MAX_LEN + 3);

  // one rating as it leaves the block
  typedef struct packed {
    logic [2:0]  distance;
    logic        became_best;
    logic [2:0]  best_distance;
    logic [15:0] best_index;
    logic        search_done;
  } rating_t;

  typedef logic [7:0] name_q_t[$];

  // tracks guess, candidate and best entry, and holds the ratings still due
  class spell_scoreboard;
    logic [7:0]  guess_mem[fsm_pkg::GUESS_MAX];
    int unsigned guess_cnt;
    bit          guess_shut;
    logic [7:0]  cand_mem[fsm_pkg::CAND_MAX];
    int unsigned cand_cnt;
    bit          cand_over;
    logic [2:0]  best_rate;
    logic [15:0] best_ord;
    logic [15:0] ord_count;
    bit          exact_hit;
    rating_t     ratings_due[$];
    int unsigned errors;

    function new();
      clear_search();
      errors = 0;
    endfunction

    function void clear_search();
      guess_cnt  = 0;
      guess_shut = 1'b0;
      cand_cnt   = 0;
      cand_over  = 1'b0;
      best_rate  = fsm_pkg::RATE_NONE;
      best_ord   = '0;
      ord_count  = '0;
      exact_hit  = 1'b0;
    endfunction

    // candidate tail from ci matches guess tail from gi
    function bit tails_match(int unsigned ci, int unsigned gi);
      if (ci > cand_cnt || gi > guess_cnt) return 1'b0;
      if (cand_cnt - ci != guess_cnt - gi) return 1'b0;
      for (int unsigned k = 0; ci + k < cand_cnt; k++) begin
        if (cand_mem[ci + k] != guess_mem[gi + k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [2:0] rate_candidate();
      int unsigned m;
      int unsigned n;
      int unsigned i;
      m = cand_cnt;
      n = guess_cnt;
      i = 0;
      // overflowed candidate can only be a prefix hit
      if (cand_over) begin
        if (n < fsm_pkg::PREFIX_MIN || n > m) return fsm_pkg::RATE_NONE;
        for (int unsigned k = 0; k < n; k++) begin
          if (cand_mem[k] != guess_mem[k]) return fsm_pkg::RATE_NONE;
        end
        return fsm_pkg::RATE_PREFIX;
      end
      while (i < m && i < n && cand_mem[i] == guess_mem[i]) i++;
      if (i == m && i == n) return fsm_pkg::RATE_EXACT;
      if (i >= fsm_pkg::PREFIX_MIN && i == n) return fsm_pkg::RATE_PREFIX;
      if (i < m) begin
        if (i < n) begin
          if (i + 1 < m && i + 1 < n && cand_mem[i] == guess_mem[i + 1] &&
              guess_mem[i] == cand_mem[i + 1] && tails_match(i + 2, i + 2))
            return fsm_pkg::RATE_SWAP;
          if (tails_match(i + 1, i + 1)) return fsm_pkg::RATE_EDIT;
        end
        if (tails_match(i + 1, i)) return fsm_pkg::RATE_EDIT;
      end
      if (i < n && tails_match(i, i + 1)) return fsm_pkg::RATE_EDIT;
      return fsm_pkg::RATE_NONE;
    endfunction

    function void note_item(logic [1:0] code, logic [7:0] data, logic fin);
      rating_t    r;
      logic [2:0] d;
      bit         took;
      case (code)
        fsm_pkg::FUNC_GUESS: begin
          if (!guess_shut) begin
            if (guess_cnt < fsm_pkg::GUESS_MAX) begin
              guess_mem[guess_cnt] = data;
              guess_cnt++;
            end
            if (fin) guess_shut = 1'b1;
          end
        end
        fsm_pkg::FUNC_CLEAR: clear_search();
        fsm_pkg::FUNC_CAND: begin
          if (!exact_hit) begin
            if (cand_cnt < fsm_pkg::CAND_MAX) begin
              cand_mem[cand_cnt] = data;
              cand_cnt++;
            end else begin
              cand_over = 1'b1;
            end
            if (fin) begin
              d = rate_candidate();
              took = (d != fsm_pkg::RATE_NONE) && (d <= best_rate);
              if (took) begin
                best_rate = d;
                best_ord  = ord_count;
                if (d == fsm_pkg::RATE_EXACT) exact_hit = 1'b1;
              end
              ord_count = ord_count + 16'd1;
              cand_cnt  = 0;
              cand_over = 1'b0;
              r.distance      = d;
              r.became_best   = took;
              r.best_distance = best_rate;
              r.best_index    = best_ord;
              r.search_done   = exact_hit;
              ratings_due.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rating_t got);
      rating_t want;
      if (ratings_due.size() == 0) begin
        $error("unexpected rating: distance %0d best %0d index %0d",
               got.distance, got.best_distance, got.best_index);
        errors++;
        return;
      end
      want = ratings_due.pop_front();
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, actual %0d", want.distance, got.distance);
        errors++;
      end
      if (got.became_best !== want.became_best) begin
        $error("became_best: expected %0d, actual %0d", want.became_best, got.became_best);
        errors++;
      end
      if (got.best_distance !== want.best_distance) begin
        $error("best_distance: expected %0d, actual %0d", want.best_distance,
               got.best_distance);
        errors++;
      end
      if (got.best_index !== want.best_index) begin
        $error("best_index: expected %0d, actual %0d", want.best_index, got.best_index);
        errors++;
      end
      if (got.search_done !== want.search_done) begin
        $error("search_done: expected %0d, actual %0d", want.search_done, got.search_done);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return ratings_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  ch;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  distance;
  logic        became_best;
  logic [2:0]  best_distance;
  logic [15:0] best_index;
  logic        search_done;

  spell_scoreboard sb = new();
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;

  filename_spelling_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .ch           (ch),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance),
    .became_best  (became_best),
    .best_distance(best_distance),
    .best_index   (best_index),
    .search_done  (search_done)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // watchdog: any run that stops moving for too long is a failure
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= LIMIT_CYCLES) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // byte pools: small alphabet makes near matches likely, full range hits every bit
  function automatic logic [7:0] pick_byte(int unsigned flavor);
    case (flavor)
      0: return 8'h61 + 8'($urandom_range(0, 3));
      2: begin
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // candidate built from the stored guess by one kind of edit, or at random
  function automatic name_q_t derive_cand(name_q_t g, int unsigned flavor);
    name_q_t     c;
    int unsigned p;
    int unsigned target;
    logic [7:0]  t;
    c = g;
    case ($urandom_range(0, 11))
      0: ;  // exact copy
      1, 2: begin  // adjacent transposition
        if (c.size() >= 2) begin
          p = $urandom_range(0, c.size() - 2);
          t = c[p];
          c[p] = c[p + 1];
          c[p + 1] = t;
        end
      end
      3, 4: begin  // substitution
        if (c.size() > 0) begin
          p = $urandom_range(0, c.size() - 1);
          c[p] = c[p] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      5: begin  // extra byte
        p = $urandom_range(0, c.size());
        c.insert(p, pick_byte(flavor));
      end
      6: begin  // missing byte
        if (c.size() > 0) begin
          p = $urandom_range(0, c.size() - 1);
          c.delete(p);
        end
      end
      7, 8: begin  // guess as a prefix
        repeat ($urandom_range(1, 6)) c.push_back(pick_byte(flavor));
      end
      9: begin  // longer than the candidate buffer
        target = $urandom_range(fsm_pkg::CAND_MAX + 1, fsm_pkg::CAND_MAX + 5);
        while (c.size() < target) c.push_back(pick_byte(flavor));
      end
      default: begin
        c.delete();
        repeat ($urandom_range(1, fsm_pkg::CAND_MAX + 2)) c.push_back(pick_byte(flavor));
      end
    endcase
    if (c.size() == 0) c.push_back(pick_byte(flavor));
    return c;
  endfunction

  // offer one item, hold it until accepted; entered and left at a falling edge
  task automatic send_item(logic [1:0] code, logic [7:0] data, logic fin);
    if (items_sent < CALM_AT && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= code;
    ch       <= data;
    last     <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(code, data, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_name(logic [1:0] code, name_q_t nm, bit close);
    foreach (nm[k]) send_item(code, nm[k], close && (k == nm.size() - 1));
  endtask

  // clear, load a guess, then a run of candidates with some noise mixed in
  task automatic run_session();
    name_q_t     guess_full;
    name_q_t     guess_kept;
    int unsigned flavor;
    int unsigned glen;
    int unsigned r;
    bit          shut;
    flavor = $urandom_range(0, 2);
    send_item(fsm_pkg::FUNC_CLEAR, pick_byte(1), 1'($urandom_range(0, 1)));
    r = $urandom_range(0, 9);
    if (r == 0) glen = 0;
    else if (r == 1) glen = $urandom_range(fsm_pkg::GUESS_MAX + 1, fsm_pkg::GUESS_MAX + 3);
    else glen = $urandom_range(1, 8);
    repeat (glen) guess_full.push_back(pick_byte(flavor));
    // now and then the guess is left open
    shut = ($urandom_range(0, 9) != 0);
    send_name(fsm_pkg::FUNC_GUESS, guess_full, shut);
    guess_kept = guess_full;
    while (guess_kept.size() > fsm_pkg::GUESS_MAX) void'(guess_kept.pop_back());
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 24))
        0: send_item(FUNC_SPARE, pick_byte(1), 1'($urandom_range(0, 1)));
        1: send_item(fsm_pkg::FUNC_GUESS, pick_byte(flavor), 1'($urandom_range(0, 1)));
        2: send_item(fsm_pkg::FUNC_CLEAR, pick_byte(1), 1'($urandom_range(0, 1)));
        // broken candidate
        3: send_name(fsm_pkg::FUNC_CAND, derive_cand(guess_kept, flavor), 1'b0);
        default: ;
      endcase
      send_name(fsm_pkg::FUNC_CAND, derive_cand(guess_kept, flavor), 1'b1);
    end
  endtask

  // receiver: random stalls, two long hold-offs to back the block up, none at the end
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned next_press;
    rating_t     got;
    stall_left = 0;
    hold_left  = 0;
    next_press = 150;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (next_press != 0 && items_sent >= next_press) begin
        hold_left  = HOLD_CYCLES;
        next_press = (next_press < 600) ? 600 : 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (items_sent >= CALM_AT) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.distance      = distance;
        got.became_best   = became_best;
        got.best_distance = best_distance;
        got.best_index    = best_index;
        got.search_done   = search_done;
        sb.check_result(got);
      end
    end
  end

  // stimulus
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    func     = fsm_pkg::FUNC_GUESS;
    ch       = 8'h00;
    last     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unused selector does nothing
    send_item(FUNC_SPARE, 8'hA5, 1'b1);
    // empty guess: one byte is a single extra byte, two bytes are no match
    send_item(fsm_pkg::FUNC_CAND, 8'h5A, 1'b1);
    send_item(fsm_pkg::FUNC_CAND, 8'hFF, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b1);
    send_item(fsm_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    // guess with zero and all-ones bytes, then a byte after the guess is closed
    send_item(fsm_pkg::FUNC_GUESS, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_GUESS, 8'hFF, 1'b0);
    send_item(fsm_pkg::FUNC_GUESS, 8'h80, 1'b1);
    send_item(fsm_pkg::FUNC_GUESS, 8'h7F, 1'b1);
    // prefix
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'hFF, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h80, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h01, 1'b1);
    // transposition
    send_item(fsm_pkg::FUNC_CAND, 8'hFF, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h80, 1'b1);
    // substitution
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h01, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h80, 1'b1);
    // missing byte
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h80, 1'b1);
    // exact match stops the search, the next candidate is ignored
    send_item(fsm_pkg::FUNC_CAND, 8'h00, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'hFF, 1'b0);
    send_item(fsm_pkg::FUNC_CAND, 8'h80, 1'b1);
    send_item(fsm_pkg::FUNC_CAND, 8'h55, 1'b1);
    send_item(fsm_pkg::FUNC_CLEAR, 8'hFF, 1'b1);

    // random sessions
    while (items_sent < ITEMS_TOTAL) run_session();
    in_valid <= 1'b0;

    // drain, then let a full rating walk go by in case something extra comes out
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
